[rtl/mhpq_pkg.sv]
// Package with the types, status codes and defaults of the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int OCC_W = 7;
    localparam int ENTRY_W = KEY_W + TAG_W;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] item_key;
        logic [TAG_W-1:0]        item_tag;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] result_key;
        logic [TAG_W-1:0]        result_tag;
        logic [1:0]              status;
        logic [OCC_W-1:0]        occupancy;
    } t_out;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

endpackage

`default_nettype wire

[rtl/mhpq_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = mhpq_pkg::ENTRY_W,
    parameter int DEPTH = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/max_heap_priority_queue.sv]
// Binary max-heap priority queue: one heap memory and a sift sequencer.
//
// Usage: an input transaction on i_in_valid/o_in_stall carries an action (insert or
// extract), a signed key and a tag. Every input transaction yields exactly one output
// transaction on o_out_valid/i_out_stall with the extracted key and tag (zero unless
// an extract succeeded), a status code and the occupancy after the operation.
// One operation is worked on at a time; o_in_stall is high while it runs.
// Sequence from the accepting cycle to the load of the output register: a rejected
// operation goes straight to the done state. An insert climbs at most log2(CAPACITY)
// levels toward the root; each level is a parent read and then a compare with write back,
// and the entry is written at the root or where it stops. An extract reads the root, then
// the last entry, and sifts that entry down; each level is a read of the left child, a
// read of the right child, a compare and the write back, and a parent with a single child
// skips the right read and the compare. The single read port of the heap memory orders
// these steps one after another. The next operation is accepted in the cycle after the load.
// Reset empties the heap at once (the count is cleared; memory contents are left as
// they are and never read before being written). When the receiver stalls, the finished
// result holds in the output register and the next operation may be accepted and run;
// it waits at its end until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire mhpq_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output mhpq_pkg::t_out      o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_EX_A   = 4'd3;
    localparam logic [3:0] S_EX_B   = 4'd4;
    localparam logic [3:0] S_EX_C   = 4'd5;
    localparam logic [3:0] S_DN_L   = 4'd6;
    localparam logic [3:0] S_DN_R   = 4'd7;
    localparam logic [3:0] S_DN_CMP = 4'd8;
    localparam logic [3:0] S_DN_DEC = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]              r_state, n_state;
    logic [AW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_count, n_count;
    mhpq_pkg::t_entry        r_entry, n_entry;
    mhpq_pkg::t_entry        r_child, n_child;
    logic [AW-1:0]           r_child_idx, n_child_idx;
    logic signed [31:0]      r_res_key, n_res_key;
    logic [15:0]             r_res_tag, n_res_tag;
    logic [1:0]              r_res_status, n_res_status;
    logic                    r_out_valid, n_out_valid;
    mhpq_pkg::t_out          r_out, n_out;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    mhpq_pkg::t_entry        ram_wdata;
    logic [mhpq_pkg::ENTRY_W-1:0] ram_rdata;
    mhpq_pkg::t_entry        rd_entry;

    logic                    in_accept;
    logic                    out_free;
    logic [IW-1:0]           left_idx;
    logic [IW-1:0]           right_idx;
    logic [IW-1:0]           count_ext;

    assign rd_entry  = mhpq_pkg::t_entry'(ram_rdata);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign count_ext = IW'(r_count);

    mhpq_ram #(
        .WIDTH (mhpq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_count      = r_count;
        n_entry      = r_entry;
        n_child      = r_child;
        n_child_idx  = r_child_idx;
        n_res_key    = r_res_key;
        n_res_tag    = r_res_tag;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_entry;
        ram_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res_key = '0;
                    n_res_tag = '0;
                    if (i_in_data.action == mhpq_pkg::ACT_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_res_status = mhpq_pkg::ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_res_status = mhpq_pkg::ST_INSERTED;
                            n_entry.key  = i_in_data.item_key;
                            n_entry.tag  = i_in_data.item_tag;
                            n_pos        = AW'(r_count);
                            n_count      = r_count + CW'(1);
                            n_state      = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = mhpq_pkg::ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_res_status = mhpq_pkg::ST_EXTRACTED;
                            n_count      = r_count - CW'(1);
                            n_state      = S_EX_A;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = AW'((r_pos - AW'(1)) >> 1);
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // The moving entry is kept in r_entry; a smaller parent drops into the hole.
                ram_we = 1'b1;
                if ($signed(r_entry.key) > $signed(rd_entry.key)) begin
                    ram_wdata = rd_entry;
                    n_pos     = AW'((r_pos - AW'(1)) >> 1);
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX_A: begin
                ram_raddr = '0;
                n_state   = S_EX_B;
            end
            S_EX_B: begin
                n_res_key = rd_entry.key;
                n_res_tag = rd_entry.tag;
                ram_raddr = AW'(r_count);
                n_state   = S_EX_C;
            end
            S_EX_C: begin
                n_entry = rd_entry;
                n_pos   = '0;
                n_state = S_DN_L;
            end
            S_DN_L: begin
                if (left_idx >= count_ext) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = AW'(left_idx);
                    n_state   = S_DN_R;
                end
            end
            S_DN_R: begin
                n_child     = rd_entry;
                n_child_idx = AW'(left_idx);
                if (right_idx < count_ext) begin
                    ram_raddr = AW'(right_idx);
                    n_state   = S_DN_CMP;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_CMP: begin
                // The right child wins only when strictly larger than the left one.
                if ($signed(rd_entry.key) > $signed(r_child.key)) begin
                    n_child     = rd_entry;
                    n_child_idx = AW'(right_idx);
                end
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                ram_we = 1'b1;
                if ($signed(r_child.key) > $signed(r_entry.key)) begin
                    ram_wdata = r_child;
                    n_pos     = r_child_idx;
                    n_state   = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.result_key     = r_res_key;
                    n_out.result_tag     = r_res_tag;
                    n_out.status         = r_res_status;
                    n_out.occupancy      = mhpq_pkg::OCC_W'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_entry      <= n_entry;
        r_child      <= n_child;
        r_child_idx  <= n_child_idx;
        r_res_key    <= n_res_key;
        r_res_tag    <= n_res_tag;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/mhpq_checker.sv]
// Port-level checker for the max-heap priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire mhpq_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire mhpq_pkg::t_out o_out_data
);

    // Reset leaves no result pending.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result is held unchanged.
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Only one operation is in flight: after a transaction the input stalls.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an operation runs");

    // Only a successful extract returns a key and a tag.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != mhpq_pkg::ST_EXTRACTED
        |-> o_out_data.result_key == '0 && o_out_data.result_tag == '0)
        else $error("non-extract result carries a key or tag");

    // An extract from an empty heap reports an empty heap.
    a_empty_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == mhpq_pkg::ST_EMPTY
        |-> o_out_data.occupancy == '0)
        else $error("empty rejection with nonzero occupancy");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
